### rtl/ica_pkg.sv
// Package for the integer calculator with decimal text output.
// Holds widths, character codes, the operation and sequencer enums and the queue item type.
// No dependencies; every rtl file refers to it by scoped names.
`default_nettype none

package ica_pkg;

  // operand and result width
  localparam int unsigned DATA_W      = 32;
  // restoring divider takes one quotient bit per step
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  // a 32-bit magnitude has at most ten decimal digits
  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
  // "error" plus newline
  localparam int unsigned ERR_LEN     = 6;
  localparam int unsigned ERR_IDX_W   = $clog2(ERR_LEN);
  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
  localparam logic [DATA_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP10_SHIFT = 35;

  // operator characters
  localparam logic [7:0] CHAR_ADD   = 8'd43;
  localparam logic [7:0] CHAR_SUB   = 8'd45;
  localparam logic [7:0] CHAR_MUL   = 8'd42;
  localparam logic [7:0] CHAR_DIV   = 8'd47;
  localparam logic [7:0] CHAR_REM   = 8'd37;
  // output characters
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_E     = 8'd101;
  localparam logic [7:0] CHAR_R     = 8'd114;
  localparam logic [7:0] CHAR_O     = 8'd111;

  // operation class decided by the front
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_REM,
    OP_DIVZERO,
    OP_NONE
  } op_e;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_LOAD,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT,
    ST_NL,
    ST_ERR
  } back_state_e;

  // one classified item waiting in the queue
  typedef struct packed {
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    op_e               op;
  } item_t;

  // characters of the divide-by-zero text
  function automatic logic [7:0] err_char(input logic [ERR_IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CHAR_E;
      3'd1:    c = CHAR_R;
      3'd2:    c = CHAR_R;
      3'd3:    c = CHAR_O;
      3'd4:    c = CHAR_R;
      default: c = CHAR_NL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/ica_front.sv
// Front end: accepts items, classifies the operator and queues them for the back end.
// Depends on ica_pkg.
`default_nettype none

module ica_front #(
  parameter int unsigned QueueDepth = ica_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output      logic                          full_o,
  input  wire logic [ica_pkg::DATA_W-1:0]    operand_a_i,
  input  wire logic [ica_pkg::DATA_W-1:0]    operand_b_i,
  input  wire logic [7:0]                    func_i,
  output      logic                          q_valid_o,
  output      ica_pkg::item_t                q_item_o,
  input  wire logic                          q_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ica_pkg::op_e   op_class;
  ica_pkg::item_t entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;
  logic            b_zero;

  // operator classification, divide by zero split off here
  assign b_zero = (operand_b_i == '0);

  always_comb begin
    unique case (func_i)
      ica_pkg::CHAR_ADD: op_class = ica_pkg::OP_ADD;
      ica_pkg::CHAR_SUB: op_class = ica_pkg::OP_SUB;
      ica_pkg::CHAR_MUL: op_class = ica_pkg::OP_MUL;
      ica_pkg::CHAR_DIV: op_class = b_zero ? ica_pkg::OP_DIVZERO : ica_pkg::OP_DIV;
      ica_pkg::CHAR_REM: op_class = b_zero ? ica_pkg::OP_DIVZERO : ica_pkg::OP_REM;
      default:           op_class = ica_pkg::OP_NONE;
    endcase
  end

  // queue control
  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign q_valid_o = (cnt_q != '0);
  assign wr_en     = push_i && !full_o;
  assign rd_en     = q_pop_i && q_valid_o;
  assign q_item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= '{operand_a: operand_a_i, operand_b: operand_b_i, op: op_class};
    end
  end

endmodule

`default_nettype wire

### rtl/ica_back.sv
// Back end: executes queued items (add, sub, shared multiplier, 32-step divider),
// converts the result to decimal one digit per cycle and emits text through an output register.
// Depends on ica_pkg.
`default_nettype none

module ica_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire ica_pkg::item_t                q_item_i,
  output      logic                          q_pop_o,
  output      logic                          empty_o,
  input  wire logic                          pop_i,
  output      logic [7:0]                    text_char_o,
  output      logic                          last_char_o
);

  localparam int unsigned W = ica_pkg::DATA_W;

  ica_pkg::back_state_e state_q, state_d;

  logic [W-1:0]                      a_q, b_q, res_q, mag_q, quo_q, rem_q, ub_q;
  logic                              neg_a_q, neg_b_q, neg_q, div_op_q;
  logic [ica_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [ica_pkg::DIG_CNT_W-1:0]     nd_q;
  logic [3:0]                        dig_q [ica_pkg::MAX_DIGITS];
  logic [ica_pkg::ERR_IDX_W-1:0]     err_idx_q;
  logic                              ov_q, olast_q;
  logic [7:0]                        och_q;

  logic                              can_emit, emit_en, emit_last;
  logic [7:0]                        emit_char;
  logic [W-1:0]                      mul_x, mul_y, q10, a_abs, b_abs, sum_ab, diff_ab;
  logic [2*W-1:0]                    prod;
  logic [3:0]                        digit, q10x10_lo;
  logic [W:0]                        trial;
  logic                              trial_ge;
  logic [ica_pkg::DIG_IDX_W-1:0]     rd_idx;

  // shared multiplier: operands for multiply, reciprocal of ten for conversion
  assign mul_x = (state_q == ica_pkg::ST_MUL) ? a_q : mag_q;
  assign mul_y = (state_q == ica_pkg::ST_MUL) ? b_q : ica_pkg::RECIP10;
  assign prod  = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
  assign q10   = W'(prod >> ica_pkg::RECIP10_SHIFT);

  // low digit: mag - 10 * (mag / 10), only four bits matter
  assign q10x10_lo = {q10[0], 3'b000} + {q10[2:0], 1'b0};
  assign digit     = mag_q[3:0] - q10x10_lo;

  // divider step on magnitudes
  assign trial    = {rem_q, quo_q[W-1]};
  assign trial_ge = (trial >= {1'b0, ub_q});

  assign a_abs   = q_item_i.operand_a[W-1] ? ('0 - q_item_i.operand_a) : q_item_i.operand_a;
  assign b_abs   = q_item_i.operand_b[W-1] ? ('0 - q_item_i.operand_b) : q_item_i.operand_b;
  assign sum_ab  = q_item_i.operand_a + q_item_i.operand_b;
  assign diff_ab = q_item_i.operand_a - q_item_i.operand_b;

  assign rd_idx   = ica_pkg::DIG_IDX_W'(nd_q - 1'b1);
  assign can_emit = !ov_q || pop_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ica_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and emit strobes
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    emit_en   = 1'b0;
    emit_last = 1'b0;
    emit_char = ica_pkg::CHAR_NL;
    unique case (state_q)
      ica_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.op)
            ica_pkg::OP_ADD,
            ica_pkg::OP_SUB:     state_d = ica_pkg::ST_LOAD;
            ica_pkg::OP_MUL:     state_d = ica_pkg::ST_MUL;
            ica_pkg::OP_DIV,
            ica_pkg::OP_REM:     state_d = ica_pkg::ST_DIV;
            ica_pkg::OP_DIVZERO: state_d = ica_pkg::ST_ERR;
            default:             state_d = ica_pkg::ST_NL;
          endcase
        end
      end
      ica_pkg::ST_MUL: state_d = ica_pkg::ST_LOAD;
      ica_pkg::ST_DIV: begin
        if (cnt_q == ica_pkg::DIV_CNT_W'(ica_pkg::DIV_STEPS - 1)) begin
          state_d = ica_pkg::ST_FIX;
        end
      end
      ica_pkg::ST_FIX:  state_d = ica_pkg::ST_LOAD;
      ica_pkg::ST_LOAD: state_d = ica_pkg::ST_CONV;
      ica_pkg::ST_CONV: begin
        if (q10 == '0) begin
          state_d = neg_q ? ica_pkg::ST_SIGN : ica_pkg::ST_DIGIT;
        end
      end
      ica_pkg::ST_SIGN: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_char = ica_pkg::CHAR_MINUS;
          state_d   = ica_pkg::ST_DIGIT;
        end
      end
      ica_pkg::ST_DIGIT: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_char = ica_pkg::CHAR_ZERO + {4'b0000, dig_q[rd_idx]};
          if (nd_q == ica_pkg::DIG_CNT_W'(1)) begin
            state_d = ica_pkg::ST_NL;
          end
        end
      end
      ica_pkg::ST_NL: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_last = 1'b1;
          emit_char = ica_pkg::CHAR_NL;
          state_d   = ica_pkg::ST_IDLE;
        end
      end
      ica_pkg::ST_ERR: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_char = ica_pkg::err_char(err_idx_q);
          if (err_idx_q == ica_pkg::ERR_IDX_W'(ica_pkg::ERR_LEN - 1)) begin
            emit_last = 1'b1;
            state_d   = ica_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ica_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ica_pkg::ST_IDLE: begin
        a_q       <= q_item_i.operand_a;
        b_q       <= q_item_i.operand_b;
        res_q     <= (q_item_i.op == ica_pkg::OP_SUB) ? diff_ab : sum_ab;
        neg_a_q   <= q_item_i.operand_a[W-1];
        neg_b_q   <= q_item_i.operand_b[W-1];
        div_op_q  <= (q_item_i.op == ica_pkg::OP_DIV);
        quo_q     <= a_abs;
        ub_q      <= b_abs;
        rem_q     <= '0;
        cnt_q     <= '0;
        err_idx_q <= '0;
      end
      ica_pkg::ST_MUL: res_q <= prod[W-1:0];
      ica_pkg::ST_DIV: begin
        rem_q <= trial_ge ? W'(trial - {1'b0, ub_q}) : trial[W-1:0];
        quo_q <= {quo_q[W-2:0], trial_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      ica_pkg::ST_FIX: begin
        if (div_op_q) begin
          res_q <= (neg_a_q ^ neg_b_q) ? ('0 - quo_q) : quo_q;
        end else begin
          res_q <= neg_a_q ? ('0 - rem_q) : rem_q;
        end
      end
      ica_pkg::ST_LOAD: begin
        neg_q <= res_q[W-1];
        mag_q <= res_q[W-1] ? ('0 - res_q) : res_q;
        nd_q  <= '0;
      end
      ica_pkg::ST_CONV: begin
        dig_q[nd_q[ica_pkg::DIG_IDX_W-1:0]] <= digit;
        nd_q  <= nd_q + 1'b1;
        mag_q <= q10;
      end
      ica_pkg::ST_DIGIT: begin
        if (can_emit) begin
          nd_q <= nd_q - 1'b1;
        end
      end
      ica_pkg::ST_ERR: begin
        if (can_emit) begin
          err_idx_q <= err_idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, one character deep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit_en) begin
      ov_q <= 1'b1;
    end else if (pop_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      och_q   <= emit_char;
      olast_q <= emit_last;
    end
  end

  assign empty_o     = !ov_q;
  assign text_char_o = och_q;
  assign last_char_o = olast_q;

endmodule

`default_nettype wire

### rtl/int_alu_with_decimal_ascii_out_core.sv
// Integer calculator with decimal ASCII output: top level.
// Instantiates ica_front (accept and classify, item queue) and ica_back (execute and print).
// Depends on ica_pkg.
//
// Usage:
//   Input channel: operand_a_i, operand_b_i, func_i; a transaction completes on a clock edge
//   with push high and full low. Output channel: text_char_o, last_char_o; the oldest
//   character sits on the ports while empty is low and leaves on an edge with pop high.
//   Each item yields its text (optional '-', decimal digits, newline) or "error" and a
//   newline for a zero divisor, or a lone newline for an unknown operator; last_char_o
//   marks the newline.
// Sequencing:
//   The back end works on one item at a time. Add and subtract go straight to conversion
//   (1 to 10 digits, one digit per cycle of conversion through the shared multiplier);
//   multiply first passes through ST_MUL; divide and remainder first pass through the
//   32-step restoring divider and the sign fixup. Text then leaves at one character per
//   cycle while pop keeps up. The front queue holds QueueDepth items.
// Reset and stalls:
//   Reset empties the queue and the output register (empty high, full low). When pop stays
//   low the character holds, the back end waits, and full rises once the queue fills.
`default_nettype none

module int_alu_with_decimal_ascii_out_core #(
  parameter int unsigned QueueDepth = ica_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output      logic                        full,
  input  wire logic [ica_pkg::DATA_W-1:0]  operand_a_i,
  input  wire logic [ica_pkg::DATA_W-1:0]  operand_b_i,
  input  wire logic [7:0]                  func_i,
  output      logic                        empty,
  input  wire logic                        pop,
  output      logic [7:0]                  text_char_o,
  output      logic                        last_char_o
);

  logic           q_valid;
  logic           q_pop;
  ica_pkg::item_t q_item;

  // accept and classify
  ica_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .func_i      (func_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  // execute and print
  ica_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

### rtl/ica_checker.sv
// Port-level checker for int_alu_with_decimal_ascii_out_core, bound to the top level.
// Depends on ica_pkg.
`default_nettype none

module ica_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] text_char_o,
  input wire logic       last_char_o
);

  // a waiting character holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(text_char_o) && $stable(last_char_o)))
    else $error("output character changed while stalled");

  // the queue only fills through an accepted transaction
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // the end marker sits only on the newline
  a_last_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_char_o) |-> (text_char_o == ica_pkg::CHAR_NL))
    else $error("last_char on a character other than newline");

  // only digits, minus, error letters and newline are ever shown
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((text_char_o >= ica_pkg::CHAR_ZERO && text_char_o <= ica_pkg::CHAR_NINE) ||
                text_char_o == ica_pkg::CHAR_MINUS || text_char_o == ica_pkg::CHAR_NL ||
                text_char_o == ica_pkg::CHAR_E || text_char_o == ica_pkg::CHAR_R ||
                text_char_o == ica_pkg::CHAR_O))
    else $error("unexpected output character");

endmodule

bind int_alu_with_decimal_ascii_out_core ica_checker u_ica_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .text_char_o (text_char_o),
  .last_char_o (last_char_o)
);

`default_nettype wire

### tb/tb.sv
// Testbench for int_alu_with_decimal_ascii_out_core: directed and random operations.
// A scoreboard class predicts the text of each operation and checks every character popped.
// Depends on ica_pkg and the rtl top level.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = ica_pkg::DATA_W;
  localparam int RANDOM_OPS = 460;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTED = 40;

  // one expected character of the printed text
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  // predicts the text for each operation and checks popped characters
  class calc_text_checker;
    text_beat_t expected_text[$];
    int         op_tags[$];
    int         mismatches;
    int         op_count;

    function new();
      mismatches = 0;
      op_count   = 0;
    endfunction

    task report(input string msg);
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void add_beat(input logic [7:0] ch, input logic last);
      text_beat_t beat;
      beat.ch   = ch;
      beat.last = last;
      expected_text.push_back(beat);
      op_tags.push_back(op_count);
    endfunction

    // compute the operation and queue its text
    function void note_operation(input logic [W-1:0] a, input logic [W-1:0] b,
                                 input logic [7:0] f);
      logic [W-1:0] r;
      logic [W-1:0] ua;
      logic [W-1:0] ub;
      logic [W-1:0] q;
      logic [W-1:0] m;
      logic [W-1:0] mag;
      logic [7:0]   digits[$];
      string        div_err;
      bit           have;
      div_err = "error\n";
      have    = 1'b1;
      r       = '0;
      case (f)
        ica_pkg::CHAR_ADD: r = a + b;
        ica_pkg::CHAR_SUB: r = a - b;
        ica_pkg::CHAR_MUL: r = a * b;
        ica_pkg::CHAR_DIV, ica_pkg::CHAR_REM: begin
          // zero divisor prints the error text
          if (b == '0) begin
            for (int i = 0; i < div_err.len(); i++)
              add_beat(div_err[i], i == div_err.len() - 1);
            op_count++;
            return;
          end
          ua = a[W-1] ? '0 - a : a;
          ub = b[W-1] ? '0 - b : b;
          q  = ua / ub;
          m  = ua % ub;
          // truncate toward zero, remainder follows the dividend
          if (f == ica_pkg::CHAR_DIV) r = (a[W-1] ^ b[W-1]) ? '0 - q : q;
          else r = a[W-1] ? '0 - m : m;
        end
        default: have = 1'b0;
      endcase
      if (have) begin
        mag = r;
        if (r[W-1]) begin
          add_beat(ica_pkg::CHAR_MINUS, 1'b0);
          mag = '0 - r;
        end
        do begin
          digits.push_front(ica_pkg::CHAR_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end while (mag != '0);
        foreach (digits[i]) add_beat(digits[i], 1'b0);
      end
      add_beat(ica_pkg::CHAR_NL, 1'b1);
      op_count++;
    endfunction

    // compare one popped character with the oldest expectation
    task check_char(input logic [7:0] ch, input logic last);
      text_beat_t beat;
      int         tag;
      if (expected_text.size() == 0) begin
        report($sformatf("character %02h with nothing expected", ch));
        return;
      end
      beat = expected_text.pop_front();
      tag  = op_tags.pop_front();
      if (ch !== beat.ch)
        report($sformatf("op %0d text_char %02h, expected %02h", tag, ch, beat.ch));
      if (last !== beat.last)
        report($sformatf("op %0d last_char %b, expected %b", tag, last, beat.last));
    endtask

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         push = 1'b0;
  logic         pop = 1'b0;
  logic [W-1:0] operand_a_i = '0;
  logic [W-1:0] operand_b_i = '0;
  logic [7:0]   func_i = '0;
  logic         full;
  logic         empty;
  logic [7:0]   text_char_o;
  logic         last_char_o;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  calc_text_checker sb = new();

  int_alu_with_decimal_ascii_out_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .func_i      (func_i),
    .empty       (empty),
    .pop         (pop),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // drive one operation and wait for its transaction
  task automatic send_op(input logic [W-1:0] a, input logic [W-1:0] b, input logic [7:0] f);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    func_i      <= f;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_operation(a, b, f);
  endtask

  // wait until every expected character has been popped
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // operand mix: full range, small, extremes, powers of ten, mid-size signed values
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    int           k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2, 3: v = $urandom;
      4, 5: v = W'($urandom_range(0, 40)) - W'(20);
      6: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          3: v = 32'h0000_0001;
          default: v = '1;
        endcase
      end
      7: begin
        v = 1;
        repeat ($urandom_range(0, 9)) v = v * 10;
        if ($urandom_range(0, 1)) v = '0 - v;
      end
      default: begin
        v = W'($urandom_range(0, 99999));
        if ($urandom_range(0, 1)) v = '0 - v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_func();
    logic [7:0] f;
    int         k;
    k = $urandom_range(0, 19);
    if (k < 4) f = ica_pkg::CHAR_ADD;
    else if (k < 8) f = ica_pkg::CHAR_SUB;
    else if (k < 11) f = ica_pkg::CHAR_MUL;
    else if (k < 15) f = ica_pkg::CHAR_DIV;
    else if (k < 18) f = ica_pkg::CHAR_REM;
    else f = 8'($urandom_range(0, 255));
    return f;
  endfunction

  // result side: random stalls on pop, checks each character transaction
  initial begin
    int gap;
    int beats;
    beats = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (beats % 37 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_char(text_char_o, last_char_o);
      beats++;
    end
  end

  // stimulus and end of run
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: wraparound, extremes, sign handling, zero divisor, unknown operators
    send_op(32'h7fff_ffff, 32'h0000_0001, ica_pkg::CHAR_ADD);
    send_op(32'h0000_0000, 32'h0000_0000, ica_pkg::CHAR_ADD);
    send_op(32'hffff_ffff, 32'h0000_0000, ica_pkg::CHAR_ADD);
    send_op(32'h8000_0000, 32'h0000_0001, ica_pkg::CHAR_SUB);
    send_op(32'h0000_0000, 32'h8000_0000, ica_pkg::CHAR_SUB);
    send_op(32'h7fff_ffff, 32'h7fff_ffff, ica_pkg::CHAR_MUL);
    send_op(32'h8000_0000, 32'hffff_ffff, ica_pkg::CHAR_MUL);
    send_op(32'd12345, 32'hffff_e57b, ica_pkg::CHAR_MUL);
    send_op(32'h8000_0000, 32'hffff_ffff, ica_pkg::CHAR_DIV);
    send_op(32'h8000_0000, 32'hffff_ffff, ica_pkg::CHAR_REM);
    send_op(32'h0000_0005, 32'h0000_0000, ica_pkg::CHAR_DIV);
    send_op(32'h8000_0000, 32'h0000_0000, ica_pkg::CHAR_REM);
    send_op(32'hffff_fff9, 32'h0000_0002, ica_pkg::CHAR_DIV);
    send_op(32'hffff_fff9, 32'h0000_0002, ica_pkg::CHAR_REM);
    send_op(32'h0000_0007, 32'hffff_fffe, ica_pkg::CHAR_REM);
    send_op(32'h7fff_ffff, 32'h8000_0000, ica_pkg::CHAR_DIV);
    send_op(32'h8000_0000, 32'h0000_0001, ica_pkg::CHAR_DIV);
    send_op(32'h8000_0000, 32'h7fff_ffff, ica_pkg::CHAR_REM);
    send_op(32'd1000000000, 32'h0000_0001, ica_pkg::CHAR_DIV);
    send_op(32'h0000_0003, 32'h0000_0004, 8'h00);
    send_op(32'hffff_ffff, 32'hffff_ffff, 8'hff);
    send_op(32'h1234_5678, 32'h0000_0000, 8'd44);

    // random operations with idle stretches and one full drain in the middle
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 41 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_OPS / 2) begin
        push <= 1'b0;
        wait_drained();
      end
      send_op(pick_operand(), pick_operand(), pick_func());
    end
    push <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
